// File: rtl/one_shot_timer_job_table_macros.svh
// Assertion macros for the timer job table RTL.
`ifndef ONE_SHOT_TIMER_JOB_TABLE_MACROS_SVH
`define ONE_SHOT_TIMER_JOB_TABLE_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define OSJT_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("osjt: invariant violated");

// Check that a consequent holds in the cycle after an antecedent.
`define OSJT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("osjt: sequence violated");

`endif

// File: rtl/osjt_pkg.sv
// Types, constants and microprogram of the timer job table.
`default_nettype none

package osjt_pkg;

    localparam int SLOTS_DEF       = 8;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int OPC_W  = 2;
    localparam int TICK_W = 32;
    localparam int HND_W  = 16;
    localparam int ID_W   = 32;
    localparam int IDX_W  = 4;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 4;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 88;

    localparam logic [TICK_W-1:0] TPS_RESET = 32'd100;
    localparam logic [ID_W-1:0]   ONE_U     = 32'd1;

    // opcodes
    localparam logic [OPC_W-1:0] OP_SCHED  = 2'd0;
    localparam logic [OPC_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OPC_W-1:0] OP_POLL   = 2'd2;
    localparam logic [OPC_W-1:0] OP_GET    = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FAIL = 2'd1;
    localparam logic [ST_W-1:0] ST_NONE = 2'd2;

    // configuration register indexes
    localparam logic REG_TPS = 1'b0;
    localparam logic REG_RUN = 1'b1;

    typedef enum logic [4:0] {
        U_IDLE,
        U_SC0, U_SC1, U_SC2, U_SC3, U_SC4,
        U_FAIL,
        U_CA0, U_CA1, U_CA2, U_CA3, U_CA4,
        U_PO0, U_PO1, U_PO2, U_PO3, U_PO4,
        U_PO5, U_PO6, U_PO7, U_PO8, U_PO9,
        U_GE0, U_GE1, U_GE2, U_GE3,
        U_NONE
    } upc_t;

    typedef enum logic [3:0] {
        A_NOP,
        A_LOAD,
        A_MUL,
        A_ADV,
        A_SCHED,
        A_CLEAR,
        A_MARK,
        A_EM_SCHED,
        A_EM_FAIL,
        A_EM_OK,
        A_EM_NONE,
        A_EM_FIRE,
        A_EM_GET
    } act_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_HND_ZERO,
        C_SLOT_FREE,
        C_AT_END,
        C_ID_HIT,
        C_DUE_HIT,
        C_SEEN_HIT,
        C_FIRE_BIT,
        C_LAST_FIRE,
        C_NONE_FIRED,
        C_RUNNER_OFF
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        upc_t  tgt;
        upc_t  nxt;
    } uword_t;

    typedef struct packed {
        logic hnd_zero;
        logic slot_free;
        logic at_end;
        logic id_hit;
        logic due_hit;
        logic seen_hit;
        logic fire_bit;
        logic last_fire;
        logic none_fired;
        logic runner_off;
        logic out_ready;
    } flags_t;

    function automatic logic is_emit(act_t a);
        return a inside {A_EM_SCHED, A_EM_FAIL, A_EM_OK, A_EM_NONE, A_EM_FIRE, A_EM_GET};
    endfunction

    function automatic upc_t entry_of(logic [OPC_W-1:0] op);
        upc_t u;
        case (op)
            OP_SCHED:  u = U_SC0;
            OP_CANCEL: u = U_CA0;
            OP_POLL:   u = U_PO0;
            OP_GET:    u = U_GE0;
            default:   u = U_IDLE;
        endcase
        return u;
    endfunction

    // Control store: action, branch condition, taken target, fall-through target.
    function automatic uword_t ucode(upc_t u);
        uword_t w;
        case (u)
            U_IDLE:  w = '{A_NOP,      C_ALWAYS,     U_IDLE, U_IDLE};
            U_SC0:   w = '{A_MUL,      C_HND_ZERO,   U_FAIL, U_SC1};
            U_SC1:   w = '{A_NOP,      C_SLOT_FREE,  U_SC3,  U_SC2};
            U_SC2:   w = '{A_ADV,      C_AT_END,     U_FAIL, U_SC1};
            U_SC3:   w = '{A_SCHED,    C_ALWAYS,     U_SC4,  U_SC4};
            U_SC4:   w = '{A_EM_SCHED, C_ALWAYS,     U_IDLE, U_IDLE};
            U_FAIL:  w = '{A_EM_FAIL,  C_ALWAYS,     U_IDLE, U_IDLE};
            U_CA0:   w = '{A_NOP,      C_ALWAYS,     U_CA1,  U_CA1};
            U_CA1:   w = '{A_NOP,      C_ID_HIT,     U_CA3,  U_CA2};
            U_CA2:   w = '{A_ADV,      C_AT_END,     U_FAIL, U_CA0};
            U_CA3:   w = '{A_CLEAR,    C_ALWAYS,     U_CA4,  U_CA4};
            U_CA4:   w = '{A_EM_OK,    C_ALWAYS,     U_IDLE, U_IDLE};
            U_PO0:   w = '{A_NOP,      C_RUNNER_OFF, U_NONE, U_PO1};
            U_PO1:   w = '{A_NOP,      C_ALWAYS,     U_PO2,  U_PO2};
            U_PO2:   w = '{A_NOP,      C_DUE_HIT,    U_PO3,  U_PO4};
            U_PO3:   w = '{A_MARK,     C_ALWAYS,     U_PO4,  U_PO4};
            U_PO4:   w = '{A_ADV,      C_AT_END,     U_PO5,  U_PO1};
            U_PO5:   w = '{A_NOP,      C_NONE_FIRED, U_NONE, U_PO6};
            U_PO6:   w = '{A_NOP,      C_ALWAYS,     U_PO7,  U_PO7};
            U_PO7:   w = '{A_NOP,      C_FIRE_BIT,   U_PO8,  U_PO9};
            U_PO8:   w = '{A_EM_FIRE,  C_LAST_FIRE,  U_IDLE, U_PO9};
            U_PO9:   w = '{A_ADV,      C_ALWAYS,     U_PO6,  U_PO6};
            U_GE0:   w = '{A_NOP,      C_ALWAYS,     U_GE1,  U_GE1};
            U_GE1:   w = '{A_NOP,      C_SEEN_HIT,   U_GE3,  U_GE2};
            U_GE2:   w = '{A_ADV,      C_AT_END,     U_FAIL, U_GE0};
            U_GE3:   w = '{A_EM_GET,   C_ALWAYS,     U_IDLE, U_IDLE};
            U_NONE:  w = '{A_EM_NONE,  C_ALWAYS,     U_IDLE, U_IDLE};
            default: w = '{A_NOP,      C_ALWAYS,     U_IDLE, U_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/osjt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module osjt_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [AW-1:0]            raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/osjt_useq.sv
// Microcode sequencer: step counter, control store fetch and branch logic.
`default_nettype none

module osjt_useq (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output      logic                        s_tready,
    input  wire logic [osjt_pkg::OPC_W-1:0]  opcode,
    input  wire osjt_pkg::flags_t            flags,
    output      osjt_pkg::act_t              act
);
    osjt_pkg::upc_t   upc_reg;
    osjt_pkg::upc_t   upc_next;
    osjt_pkg::uword_t uw;
    logic             cond_hit;
    logic             accept;

    assign uw       = osjt_pkg::ucode(upc_reg);
    assign s_tready = (upc_reg == osjt_pkg::U_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        case (uw.cond)
            osjt_pkg::C_ALWAYS:     cond_hit = 1'b1;
            osjt_pkg::C_HND_ZERO:   cond_hit = flags.hnd_zero;
            osjt_pkg::C_SLOT_FREE:  cond_hit = flags.slot_free;
            osjt_pkg::C_AT_END:     cond_hit = flags.at_end;
            osjt_pkg::C_ID_HIT:     cond_hit = flags.id_hit;
            osjt_pkg::C_DUE_HIT:    cond_hit = flags.due_hit;
            osjt_pkg::C_SEEN_HIT:   cond_hit = flags.seen_hit;
            osjt_pkg::C_FIRE_BIT:   cond_hit = flags.fire_bit;
            osjt_pkg::C_LAST_FIRE:  cond_hit = flags.last_fire;
            osjt_pkg::C_NONE_FIRED: cond_hit = flags.none_fired;
            osjt_pkg::C_RUNNER_OFF: cond_hit = flags.runner_off;
            default:                cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        if (upc_reg == osjt_pkg::U_IDLE) begin
            act      = accept ? osjt_pkg::A_LOAD : osjt_pkg::A_NOP;
            upc_next = accept ? osjt_pkg::entry_of(opcode) : osjt_pkg::U_IDLE;
        end else if (osjt_pkg::is_emit(uw.act) && !flags.out_ready) begin
            // hold the step until the output register frees up
            act      = osjt_pkg::A_NOP;
            upc_next = upc_reg;
        end else begin
            act      = uw.act;
            upc_next = cond_hit ? uw.tgt : uw.nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= osjt_pkg::U_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/osjt_dpath.sv
// Datapath: slot flags, slot RAM, scan pointer, id counter and result register.
`default_nettype none

module osjt_dpath #(
    parameter int SLOTS       = osjt_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS = osjt_pkg::HANDLE_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire osjt_pkg::act_t               act,
    input  wire logic [osjt_pkg::TICK_W-1:0]  now_tick,
    input  wire logic [osjt_pkg::TICK_W-1:0]  delay_seconds,
    input  wire logic [osjt_pkg::HND_W-1:0]   command_handle,
    input  wire logic [osjt_pkg::ID_W-1:0]    target_id,
    input  wire logic [osjt_pkg::IDX_W-1:0]   entry_index,
    input  wire logic                         cfg_valid,
    input  wire logic                         cfg_index,
    input  wire logic [osjt_pkg::TICK_W-1:0]  cfg_data,
    output      osjt_pkg::flags_t             flags,
    input  wire logic                         m_tready,
    output      logic                         m_tvalid,
    output      logic [osjt_pkg::ST_W-1:0]    status,
    output      logic [osjt_pkg::ID_W-1:0]    job_id,
    output      logic [osjt_pkg::HND_W-1:0]   handle_out,
    output      logic [osjt_pkg::TICK_W-1:0]  due_out,
    output      logic [osjt_pkg::CNT_W-1:0]   pending_count,
    output      logic                         last
);
`include "one_shot_timer_job_table_macros.svh"

    localparam int PW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int IW    = (CW > osjt_pkg::IDX_W) ? CW : osjt_pkg::IDX_W;
    localparam int TW    = osjt_pkg::TICK_W;
    localparam int HW    = osjt_pkg::HND_W;
    localparam int RW    = osjt_pkg::ID_W + TW + HANDLE_BITS;
    localparam int DUE_L = osjt_pkg::ID_W;
    localparam int HND_L = osjt_pkg::ID_W + TW;

    // configuration
    logic [TW-1:0] tps_reg, tps_next;
    logic          run_reg, run_next;

    // latched item
    logic [TW-1:0]                  now_reg, now_next;
    logic [TW-1:0]                  secs_reg, secs_next;
    logic [HANDLE_BITS-1:0]         hnd_reg, hnd_next;
    logic [osjt_pkg::ID_W-1:0]      tid_reg, tid_next;
    logic [osjt_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [TW-1:0]                  prod_reg, prod_next;

    // scan state
    logic [PW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    seen_reg, seen_next;
    logic [SLOTS-1:0] pend_reg, pend_next;
    logic [SLOTS-1:0] fire_reg, fire_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    fcnt_reg, fcnt_next;
    logic [osjt_pkg::ID_W-1:0] nid_reg, nid_next;

    // result register
    logic                       m_valid_reg, m_valid_next;
    logic [osjt_pkg::ST_W-1:0]  m_st_reg, m_st_next;
    logic [osjt_pkg::ID_W-1:0]  m_id_reg, m_id_next;
    logic [HW-1:0]              m_hnd_reg, m_hnd_next;
    logic [TW-1:0]              m_due_reg, m_due_next;
    logic [osjt_pkg::CNT_W-1:0] m_cnt_reg, m_cnt_next;
    logic                       m_last_reg, m_last_next;

    // slot RAM
    logic          ram_we;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;

    logic [osjt_pkg::ID_W-1:0]     rd_id;
    logic [TW-1:0]                 rd_due;
    logic [HANDLE_BITS-1:0]        rd_hnd;
    logic [HANDLE_BITS+HW-1:0]     hin_x;
    logic [HANDLE_BITS+HW-1:0]     rdh_x;
    logic [HANDLE_BITS+HW-1:0]     hreg_x;
    logic [CW+osjt_pkg::CNT_W-1:0] cnt_x;
    logic [TW-1:0]                 secs_eff;
    logic                          at_end;
    logic                          pend_here;
    logic [PW-1:0]                 ptr_inc;

    osjt_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (ram_wdata),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    assign rd_id  = ram_rdata[DUE_L-1:0];
    assign rd_due = ram_rdata[HND_L-1:DUE_L];
    assign rd_hnd = ram_rdata[RW-1:HND_L];

    assign hin_x  = {{HANDLE_BITS{1'b0}}, command_handle};
    assign rdh_x  = {{HW{1'b0}}, rd_hnd};
    assign hreg_x = {{HW{1'b0}}, hnd_reg};
    assign cnt_x  = {{osjt_pkg::CNT_W{1'b0}}, cnt_reg};

    assign secs_eff  = (secs_reg == '0) ? osjt_pkg::ONE_U : secs_reg;
    assign at_end    = (ptr_reg == PW'(SLOTS - 1));
    assign pend_here = pend_reg[ptr_reg];
    assign ptr_inc   = at_end ? '0 : ptr_reg + PW'(1);
    assign ram_wdata = {hnd_reg, now_reg + prod_reg, nid_reg};

    always_comb begin
        flags.hnd_zero   = (hnd_reg == '0);
        flags.slot_free  = !pend_here;
        flags.at_end     = at_end;
        flags.id_hit     = pend_here && (rd_id == tid_reg);
        flags.due_hit    = pend_here && (now_reg >= rd_due);
        flags.seen_hit   = pend_here && (IW'(seen_reg) == IW'(idx_reg));
        flags.fire_bit   = fire_reg[ptr_reg];
        flags.last_fire  = (fcnt_reg == CW'(1));
        flags.none_fired = (fcnt_reg == '0);
        flags.runner_off = !run_reg;
        flags.out_ready  = !m_valid_reg || m_tready;
    end

    always_comb begin
        tps_next     = tps_reg;
        run_next     = run_reg;
        now_next     = now_reg;
        secs_next    = secs_reg;
        hnd_next     = hnd_reg;
        tid_next     = tid_reg;
        idx_next     = idx_reg;
        prod_next    = prod_reg;
        ptr_next     = ptr_reg;
        seen_next    = seen_reg;
        pend_next    = pend_reg;
        fire_next    = fire_reg;
        cnt_next     = cnt_reg;
        fcnt_next    = fcnt_reg;
        nid_next     = nid_reg;
        ram_we       = 1'b0;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        m_st_next    = m_st_reg;
        m_id_next    = m_id_reg;
        m_hnd_next   = m_hnd_reg;
        m_due_next   = m_due_reg;
        m_cnt_next   = m_cnt_reg;
        m_last_next  = m_last_reg;

        if (cfg_valid) begin
            case (cfg_index)
                osjt_pkg::REG_TPS: tps_next = cfg_data;
                osjt_pkg::REG_RUN: run_next = cfg_data[0];
                default: ;
            endcase
        end

        if (osjt_pkg::is_emit(act)) begin
            m_valid_next = 1'b1;
            m_st_next    = osjt_pkg::ST_OK;
            m_id_next    = '0;
            m_hnd_next   = '0;
            m_due_next   = '0;
            m_cnt_next   = cnt_x[osjt_pkg::CNT_W-1:0];
            m_last_next  = 1'b1;
        end

        case (act)
            osjt_pkg::A_LOAD: begin
                now_next  = now_tick;
                secs_next = delay_seconds;
                hnd_next  = hin_x[HANDLE_BITS-1:0];
                tid_next  = target_id;
                idx_next  = entry_index;
                ptr_next  = '0;
                seen_next = '0;
            end
            osjt_pkg::A_MUL: begin
                prod_next = TW'(secs_eff * tps_reg);
            end
            osjt_pkg::A_ADV: begin
                ptr_next  = ptr_inc;
                seen_next = seen_reg + CW'(pend_here);
            end
            osjt_pkg::A_SCHED: begin
                ram_we             = 1'b1;
                pend_next[ptr_reg] = 1'b1;
                cnt_next           = cnt_reg + CW'(1);
                nid_next           = nid_reg + osjt_pkg::ONE_U;
            end
            osjt_pkg::A_CLEAR: begin
                pend_next[ptr_reg] = 1'b0;
                cnt_next           = cnt_reg - CW'(1);
            end
            osjt_pkg::A_MARK: begin
                pend_next[ptr_reg] = 1'b0;
                fire_next[ptr_reg] = 1'b1;
                cnt_next           = cnt_reg - CW'(1);
                fcnt_next          = fcnt_reg + CW'(1);
            end
            osjt_pkg::A_EM_SCHED: begin
                // the counter has already moved past the id just given out
                m_id_next  = nid_reg - osjt_pkg::ONE_U;
                m_hnd_next = hreg_x[HW-1:0];
            end
            osjt_pkg::A_EM_FAIL: begin
                m_st_next = osjt_pkg::ST_FAIL;
            end
            osjt_pkg::A_EM_OK: begin
                m_st_next = osjt_pkg::ST_OK;
            end
            osjt_pkg::A_EM_NONE: begin
                m_st_next = osjt_pkg::ST_NONE;
            end
            osjt_pkg::A_EM_FIRE: begin
                m_id_next          = rd_id;
                m_hnd_next         = rdh_x[HW-1:0];
                m_last_next        = (fcnt_reg == CW'(1));
                fire_next[ptr_reg] = 1'b0;
                fcnt_next          = fcnt_reg - CW'(1);
            end
            osjt_pkg::A_EM_GET: begin
                m_id_next  = rd_id;
                m_hnd_next = rdh_x[HW-1:0];
                m_due_next = rd_due;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg     <= osjt_pkg::TPS_RESET;
            run_reg     <= 1'b0;
            pend_reg    <= '0;
            fire_reg    <= '0;
            cnt_reg     <= '0;
            fcnt_reg    <= '0;
            nid_reg     <= osjt_pkg::ONE_U;
            ptr_reg     <= '0;
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            tps_reg     <= tps_next;
            run_reg     <= run_next;
            pend_reg    <= pend_next;
            fire_reg    <= fire_next;
            cnt_reg     <= cnt_next;
            fcnt_reg    <= fcnt_next;
            nid_reg     <= nid_next;
            ptr_reg     <= ptr_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg    <= now_next;
        secs_reg   <= secs_next;
        hnd_reg    <= hnd_next;
        tid_reg    <= tid_next;
        idx_reg    <= idx_next;
        prod_reg   <= prod_next;
        m_st_reg   <= m_st_next;
        m_id_reg   <= m_id_next;
        m_hnd_reg  <= m_hnd_next;
        m_due_reg  <= m_due_next;
        m_cnt_reg  <= m_cnt_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid      = m_valid_reg;
    assign status        = m_st_reg;
    assign job_id        = m_id_reg;
    assign handle_out    = m_hnd_reg;
    assign due_out       = m_due_reg;
    assign pending_count = m_cnt_reg;
    assign last          = m_last_reg;

    `OSJT_ASSERT_ALWAYS(a_cnt_matches_flags, aclk, aresetn,
        $countones(pend_reg) == int'(cnt_reg))
    `OSJT_ASSERT_ALWAYS(a_fcnt_matches_flags, aclk, aresetn,
        $countones(fire_reg) == int'(fcnt_reg))
    `OSJT_ASSERT_ALWAYS(a_fire_not_pending, aclk, aresetn,
        (pend_reg & fire_reg) == '0)
    `OSJT_ASSERT_NEXT(a_sched_marks_slot, aclk, aresetn,
        act == osjt_pkg::A_SCHED, pend_reg[$past(ptr_reg)])

endmodule

`default_nettype wire

// File: rtl/one_shot_timer_job_table.sv
// Top level of the one-shot timer job table.
// The block holds SLOTS one-shot jobs (id, due tick, command handle) in a small
// RAM, with a pending flag per slot in flip-flops. A short microprogram in a
// read-only control store walks a scan pointer over the slots, one slot at a
// time, and drives a plain datapath (one 32x32 multiplier for the due tick,
// compares, counters, one result register). Items are taken one at a time:
// s_tready is high only while the sequencer is idle. The slot RAM has one
// registered read port, so each slot whose contents are tested costs a read
// step before its test step. Schedule takes the first free slot and fails on
// an empty handle or a full table; cancel clears the first pending job with
// the target id; get returns the pending job at entry_index in slot order;
// both fail when the scan ends without a hit. Poll answers none with the
// runner absent, otherwise one pass marks every due job as fired, then one
// result is given per fired job (a none result when nothing is due).
// A stalled result holds the sequencer at its emit step. The output register
// frees the sequencer as soon as the last result is loaded, so the next item is
// accepted while that result still waits on m_tready. Configuration writes are
// accepted on every cycle (cfg_ready is tied high) and must be issued only
// while the block is idle.
`default_nettype none

module one_shot_timer_job_table #(
    parameter int SLOTS       = osjt_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS = osjt_pkg::HANDLE_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // command items
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    // now_tick[31:0], delay_seconds[63:32], command_handle[79:64],
    // target_id[111:80], entry_index[115:112], zero pad[119:116]
    input  wire logic [osjt_pkg::S_TDATA_W-1:0]    s_tdata,
    // opcode[1:0]
    input  wire logic [osjt_pkg::OPC_W-1:0]        s_tuser,
    // result items
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // job_id[31:0], handle_out[47:32], due_out[79:48], pending_count[83:80],
    // zero pad[87:84]
    output      logic [osjt_pkg::M_TDATA_W-1:0]    m_tdata,
    // status[1:0]
    output      logic [osjt_pkg::ST_W-1:0]         m_tuser,
    output      logic                              m_tlast,
    // configuration writes: index 0 ticks_per_second, index 1 runner_present
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic                              cfg_index,
    input  wire logic [osjt_pkg::TICK_W-1:0]       cfg_data
);
    osjt_pkg::flags_t flags;
    osjt_pkg::act_t   act;

    logic [osjt_pkg::TICK_W-1:0] now_tick;
    logic [osjt_pkg::TICK_W-1:0] delay_seconds;
    logic [osjt_pkg::HND_W-1:0]  command_handle;
    logic [osjt_pkg::ID_W-1:0]   target_id;
    logic [osjt_pkg::IDX_W-1:0]  entry_index;

    logic [osjt_pkg::ST_W-1:0]   status;
    logic [osjt_pkg::ID_W-1:0]   job_id;
    logic [osjt_pkg::HND_W-1:0]  handle_out;
    logic [osjt_pkg::TICK_W-1:0] due_out;
    logic [osjt_pkg::CNT_W-1:0]  pending_count;

    // unpack the command item
    assign now_tick       = s_tdata[31:0];
    assign delay_seconds  = s_tdata[63:32];
    assign command_handle = s_tdata[79:64];
    assign target_id      = s_tdata[111:80];
    assign entry_index    = s_tdata[115:112];

    assign cfg_ready = 1'b1;

    osjt_useq u_useq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .flags    (flags),
        .act      (act)
    );

    osjt_dpath #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .act            (act),
        .now_tick       (now_tick),
        .delay_seconds  (delay_seconds),
        .command_handle (command_handle),
        .target_id      (target_id),
        .entry_index    (entry_index),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .flags          (flags),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .status         (status),
        .job_id         (job_id),
        .handle_out     (handle_out),
        .due_out        (due_out),
        .pending_count  (pending_count),
        .last           (m_tlast)
    );

    // pack the result item, padding to whole bytes
    assign m_tdata = {4'b0000, pending_count, due_out, handle_out, job_id};
    assign m_tuser = status;

endmodule

`default_nettype wire

// File: tb/one_shot_timer_job_table_checker.sv
// Checker for the timer job table: predicts every result from the observed items.
`timescale 1ns / 1ps

module one_shot_timer_job_table_checker
    import osjt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [OPC_W-1:0]      s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic [ST_W-1:0]       m_tuser,
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [TICK_W-1:0]     cfg_data,
    output int                    results_outstanding,
    output int                    mismatch_count
);

    localparam int NSLOT = SLOTS_DEF;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ID_W-1:0]   job_id;
        logic [HND_W-1:0]  handle;
        logic [TICK_W-1:0] due;
        logic [CNT_W-1:0]  count;
        logic              last;
    } job_result_t;

    logic              job_live   [NSLOT];
    logic [ID_W-1:0]   job_ident  [NSLOT];
    logic [TICK_W-1:0] job_due    [NSLOT];
    logic [HND_W-1:0]  job_handle [NSLOT];
    logic [ID_W-1:0]   next_job_id;
    logic [TICK_W-1:0] tick_rate;
    logic              runner_on;

    job_result_t results_due[$];
    int          errors = 0;

    function automatic job_result_t make_result(logic [ST_W-1:0] st, logic [ID_W-1:0] id,
                                                logic [HND_W-1:0] h, logic [TICK_W-1:0] due);
        job_result_t r;
        r.status = st;
        r.job_id = id;
        r.handle = h;
        r.due    = due;
        r.count  = '0;
        r.last   = 1'b0;
        return r;
    endfunction

    // Apply one command to the table copy and queue the results it gives.
    task automatic predict_command(input logic [OPC_W-1:0] op, input logic [S_TDATA_W-1:0] td);
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] secs;
        logic [HND_W-1:0]  hnd;
        logic [ID_W-1:0]   tid;
        logic [IDX_W-1:0]  idx;
        job_result_t       step_out[$];
        job_result_t       r;
        int                slot;
        int                seen;
        int                live;
        logic [ST_W-1:0]   st;
        now  = td[31:0];
        secs = td[63:32];
        hnd  = td[79:64];
        tid  = td[111:80];
        idx  = td[115:112];
        slot = -1;
        seen = 0;
        live = 0;
        case (op)
            OP_SCHED: begin
                if (hnd != '0) begin
                    for (int i = 0; i < NSLOT; i++)
                        if (slot < 0 && !job_live[i]) slot = i;
                end
                if (slot < 0) begin
                    step_out.push_back(make_result(ST_FAIL, '0, '0, '0));
                end else begin
                    if (secs == '0) secs = 32'd1;
                    job_live[slot]   = 1'b1;
                    job_ident[slot]  = next_job_id;
                    job_due[slot]    = now + secs * tick_rate;
                    job_handle[slot] = hnd;
                    next_job_id      = next_job_id + 32'd1;
                    step_out.push_back(make_result(ST_OK, job_ident[slot], hnd, '0));
                end
            end
            OP_CANCEL: begin
                st = ST_FAIL;
                for (int i = 0; i < NSLOT; i++) begin
                    if (st == ST_FAIL && job_live[i] && job_ident[i] == tid) begin
                        job_live[i] = 1'b0;
                        st = ST_OK;
                    end
                end
                step_out.push_back(make_result(st, '0, '0, '0));
            end
            OP_POLL: begin
                if (runner_on) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (job_live[i] && now >= job_due[i]) begin
                            job_live[i] = 1'b0;
                            step_out.push_back(make_result(ST_OK, job_ident[i], job_handle[i], '0));
                        end
                    end
                end
                if (step_out.size() == 0) step_out.push_back(make_result(ST_NONE, '0, '0, '0));
            end
            default: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (job_live[i]) begin
                        if (slot < 0 && seen == idx) slot = i;
                        seen++;
                    end
                end
                if (slot < 0)
                    step_out.push_back(make_result(ST_FAIL, '0, '0, '0));
                else
                    step_out.push_back(make_result(ST_OK, job_ident[slot], job_handle[slot],
                                                   job_due[slot]));
            end
        endcase
        // pending count is taken after the whole command
        for (int i = 0; i < NSLOT; i++)
            if (job_live[i]) live++;
        foreach (step_out[k]) begin
            r = step_out[k];
            r.count = live[CNT_W-1:0];
            r.last  = (k == step_out.size() - 1);
            results_due.push_back(r);
        end
    endtask

    task automatic report_result(input string what, input job_result_t want,
                                 input job_result_t got);
        if (errors < 10)
            $display("%0t %s: want st=%0d id=%h hnd=%h due=%h cnt=%0d last=%b,",
                     $realtime, what, want.status, want.job_id, want.handle, want.due,
                     want.count, want.last,
                     " got st=%0d id=%h hnd=%h due=%h cnt=%0d last=%b",
                     got.status, got.job_id, got.handle, got.due, got.count, got.last);
        errors++;
    endtask

    always @(posedge aclk) begin
        job_result_t got;
        job_result_t want;
        if (!aresetn) begin
            foreach (job_live[i]) begin
                job_live[i]   = 1'b0;
                job_ident[i]  = '0;
                job_due[i]    = '0;
                job_handle[i] = '0;
            end
            next_job_id = 32'd1;
            tick_rate   = TPS_RESET;
            runner_on   = 1'b0;
            results_due.delete();
        end else begin
            // compare first: a result leaving at this edge belongs to an earlier item
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.job_id = m_tdata[31:0];
                got.handle = m_tdata[47:32];
                got.due    = m_tdata[79:48];
                got.count  = m_tdata[83:80];
                got.last   = m_tlast;
                if (results_due.size() == 0) begin
                    report_result("unexpected result", '0, got);
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) report_result("result mismatch", want, got);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TPS: tick_rate = cfg_data;
                    REG_RUN: runner_on = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_command(s_tuser, s_tdata);
        end
        results_outstanding <= results_due.size();
        mismatch_count      <= errors;
    end

endmodule

// File: tb/one_shot_timer_job_table_tb.sv
// Testbench top for the timer job table: stimulus, idling phases and verdict.
`timescale 1ns / 1ps

module one_shot_timer_job_table_tb;
    import osjt_pkg::*;

    // Allow plenty for the slowest poll with eight stalled results.
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int          RANDOM_PER_PHASE = 47;
    localparam int          SETTLE_CYCLES = 60;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [OPC_W-1:0]     s_tuser   = OP_POLL;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [ST_W-1:0]      m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = REG_TPS;
    logic [TICK_W-1:0]    cfg_data  = '0;

    int                   results_outstanding;
    int                   mismatch_count;
    int unsigned          cycles = 0;

    // idling odds in percent, changed per phase
    int                   send_idle_pct = 0;
    int                   take_stall_pct = 0;

    // rough view of the id counter and the time base, for aiming cancels and polls
    logic [ID_W-1:0]      id_hint = 32'd10;
    logic [TICK_W-1:0]    tick_now = '0;

    one_shot_timer_job_table uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    one_shot_timer_job_table_checker checker_i (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tuser             (m_tuser),
        .m_tlast             (m_tlast),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .results_outstanding (results_outstanding),
        .mismatch_count      (mismatch_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result side at random; zero odds keep m_tready high throughout.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= take_stall_pct);
    end

    // Guard against a hang: a missing result or a stuck handshake ends here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Present one command item and hold it until accepted. Leave s_tvalid high so a
    // back-to-back item follows without a bubble.
    task automatic send_command(input logic [OPC_W-1:0] op, input logic [TICK_W-1:0] now,
                                input logic [TICK_W-1:0] secs, input logic [HND_W-1:0] hnd,
                                input logic [ID_W-1:0] tid, input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, idx, tid, hnd, secs, now};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid and wait until every predicted result has left the block.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_outstanding != 0) @(posedge aclk);
    endtask

    // Write both registers back to back; only called with the block idle.
    task automatic set_rates(input logic [TICK_W-1:0] tps, input logic run);
        cfg_valid <= 1'b1;
        cfg_index <= REG_TPS;
        cfg_data  <= tps;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= REG_RUN;
        cfg_data  <= {31'd0, run};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed traffic around a moving time base, with some noise mixed in.
    task automatic random_command();
        int                pick;
        logic [OPC_W-1:0]  op;
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] secs;
        logic [HND_W-1:0]  hnd;
        logic [ID_W-1:0]   tid;
        logic [IDX_W-1:0]  idx;
        pick     = $urandom_range(99);
        tick_now = tick_now + $urandom_range(0, 8);
        now      = tick_now;
        secs     = $urandom_range(0, 20);
        hnd      = 16'($urandom_range(1, 16'hFFFF));
        tid      = $urandom;
        idx      = 4'($urandom_range(0, 15));
        if (pick < 38) begin
            op = OP_SCHED;
            if ($urandom_range(9) == 0) hnd = '0;
            if ($urandom_range(4) == 0) secs = $urandom;
            if (hnd != '0) id_hint = id_hint + 1;
        end else if (pick < 56) begin
            op = OP_CANCEL;
            // aim at recently issued ids most of the time
            if ($urandom_range(4) != 0) tid = id_hint - $urandom_range(0, 10);
        end else if (pick < 80) begin
            op = OP_POLL;
            now = tick_now + $urandom_range(0, 25);
            if ($urandom_range(11) == 0) now = 32'hFFFF_FFFF;
        end else begin
            op = OP_GET;
            if ($urandom_range(3) != 0) idx = 4'($urandom_range(0, 8));
        end
        if ($urandom_range(19) == 0) now = $urandom;
        send_command(op, now, secs, hnd, tid, idx);
    endtask

    initial begin
        int idle_send[4];
        int idle_take[4];
        idle_send = '{0, 69, 0, 34};
        idle_take = '{0, 0, 69, 34};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset settings: runner absent, 100 ticks per second.
        send_command(OP_POLL,   32'd500, '0, '0, '0, '0);
        send_command(OP_GET,    '0, '0, '0, '0, 4'd0);
        send_command(OP_CANCEL, '0, '0, '0, 32'd5, '0);
        send_command(OP_SCHED,  32'd10, 32'd3, 16'h0000, '0, '0);
        // fill all eight slots, ids 1 to 8, with extreme ticks, delays and handles
        send_command(OP_SCHED,  32'd0,         32'd0,         16'h0001, '0, '0);
        send_command(OP_SCHED,  32'hFFFF_FFFF, 32'd1,         16'hFFFF, '0, '0);
        send_command(OP_SCHED,  32'd1000,      32'hFFFF_FFFF, 16'h8000, '0, '0);
        send_command(OP_SCHED,  32'h8000_0000, 32'd7,         16'h5555, '0, '0);
        send_command(OP_SCHED,  32'd20,        32'd0,         16'hAAAA, '0, '0);
        send_command(OP_SCHED,  32'h7FFF_FFFF, 32'd2,         16'h00FF, '0, '0);
        send_command(OP_SCHED,  32'd300,       32'h0100_0000, 16'hFF00, '0, '0);
        send_command(OP_SCHED,  32'd42,        32'd5,         16'h1234, '0, '0);
        // table full
        send_command(OP_SCHED,  32'd1,         32'd1,         16'h0777, '0, '0);
        send_command(OP_GET,    '0, '0, '0, '0, 4'd0);
        send_command(OP_GET,    '0, '0, '0, '0, 4'd7);
        send_command(OP_GET,    '0, '0, '0, '0, 4'd8);
        send_command(OP_GET,    '0, '0, '0, '0, 4'd15);
        drain_results();

        set_rates(TPS_RESET, 1'b1);
        send_command(OP_CANCEL, '0, '0, '0, 32'd3, '0);
        send_command(OP_CANCEL, '0, '0, '0, 32'd3, '0);
        send_command(OP_CANCEL, '0, '0, '0, 32'hFFFF_FFFF, '0);
        // flush every pending job at the top of the tick range
        send_command(OP_POLL,   32'hFFFF_FFFF, '0, '0, '0, '0);
        drain_results();

        // zero rate: due at the scheduling tick itself
        set_rates('0, 1'b1);
        send_command(OP_SCHED,  32'd1234, 32'd7, 16'h5A5A, '0, '0);
        send_command(OP_POLL,   32'd1233, '0, '0, '0, '0);
        send_command(OP_POLL,   32'd1234, '0, '0, '0, '0);
        drain_results();

        // Random part: one idling pattern and one register setting per phase.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       set_rates(32'd1, 1'b1);
                1:       set_rates(32'hFFFF_FFFF, 1'b1);
                2:       set_rates($urandom_range(1, 1000), 1'b1);
                default: set_rates($urandom | 32'd1, 1'($urandom_range(1)));
            endcase
            send_idle_pct  = idle_send[ph];
            take_stall_pct = idle_take[ph];
            tick_now       = $urandom;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) random_command();
            drain_results();
        end

        // let any stray result surface before the verdict
        take_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
